// ===== hw/rtl/rpi_pkg.sv =====
package rpi_pkg;

  localparam int FACE_COUNT = 6;
  localparam int CORNERS    = 4;
  localparam int QDEPTH     = 2;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_TRACE = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [2:0] SLOT_NORMAL = 3'd4;
  localparam logic [2:0] SLOT_OFFSET = 3'd5;

  typedef enum logic [2:0] {
    K_CORNER,
    K_NORMAL,
    K_OFFSET,
    K_TRACE,
    K_QUERY
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         face;
    logic [1:0]         corner;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SN,
    S_DC,
    S_DA,
    S_DIV,
    S_PT,
    S_EA,
    S_EB,
    S_EC,
    S_ED,
    S_EMUL,
    S_DIST,
    S_NEXT,
    S_QD,
    S_OUT
  } bstate_t;

  // projection planes
  localparam logic [1:0] PL_XY = 2'd0;
  localparam logic [1:0] PL_ZY = 2'd1;
  localparam logic [1:0] PL_XZ = 2'd2;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] == v[31]) return v[31:0];
    return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if ((&v[63:31]) || !(|v[63:31])) return v[31:0];
    return v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [31:0] sat65(input logic signed [64:0] v);
    if ((&v[64:31]) || !(|v[64:31])) return v[31:0];
    return v[64] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [31:0] pick3(input logic signed [31:0] v0,
                                               input logic signed [31:0] v1,
                                               input logic signed [31:0] v2,
                                               input logic [1:0] k);
    case (k)
      2'd0: return v0;
      2'd1: return v1;
      default: return v2;
    endcase
  endfunction

endpackage

// ===== hw/rtl/ray_prism_intersection.sv =====
// ray against a six-faced convex prism, signed fixed point with FRAC_BITS
// fraction bits. input channel in_valid/in_ready takes one transaction per
// request: face loads (corner, normal, plane offset), ray traces and normal
// queries. traces and queries each give one transaction on out_valid/out_ready;
// loads and unused requests give none. eps_we writes the tolerance register.
// a front stage classifies requests into a two-entry queue; the back end runs
// them in order on one 32x32 multiplier and a one-bit-per-cycle divider.
// loads are stored as they are popped. queries test each face in turn.
// trace: per face the dot products, the division, then the hit point, edge
// tests and distance, and a step on to the next face; faces rejected early
// skip the later steps. the divider and the shared multiplier set the pace.
// reset empties the queue, drops any result in flight and sets epsilon to 66;
// face data is undefined until loaded. when out_ready is low the result is
// held, the back end waits, and the front keeps taking requests until the
// queue is full.
module ray_prism_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               eps_we,
  input  logic [15:0]        eps_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [2:0]         face_index,
  input  logic [2:0]         slot_index,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z
);
  import rpi_pkg::*;

  localparam logic [15:0] EPS_RESET = 16'd66;

  logic [15:0] eps;
  logic        push;
  logic        full;
  logic        pop;
  logic        empty;
  cmd_t        fcmd;
  cmd_t        bcmd;

  always_ff @(posedge clk) begin
    if (rst) eps <= EPS_RESET;
    else if (eps_we) eps <= eps_wdata;
  end

  rpi_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .face_index (face_index),
    .slot_index (slot_index),
    .a_x        (a_x),
    .a_y        (a_y),
    .a_z        (a_z),
    .b_x        (b_x),
    .b_y        (b_y),
    .b_z        (b_z),
    .full       (full),
    .push       (push),
    .cmd        (fcmd)
  );

  rpi_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (fcmd),
    .full  (full),
    .pop   (pop),
    .rdata (bcmd),
    .empty (empty)
  );

  rpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .eps       (eps),
    .empty     (empty),
    .cmd       (bcmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z)
  );

endmodule

// ===== hw/rtl/rpi_front.sv =====
module rpi_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [2:0]         face_index,
  input  logic [2:0]         slot_index,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic               full,
  output logic               push,
  output rpi_pkg::cmd_t      cmd
);
  import rpi_pkg::*;

  logic keep;

  always_comb begin
    keep = 1'b0;
    cmd.kind = K_TRACE;
    cmd.face = face_index;
    cmd.corner = slot_index[1:0];
    cmd.ax = a_x;
    cmd.ay = a_y;
    cmd.az = a_z;
    cmd.bx = b_x;
    cmd.by = b_y;
    cmd.bz = b_z;
    case (req_type)
      REQ_LOAD: begin
        // loads beyond the face or slot range are dropped here
        if (face_index < 3'(FACE_COUNT)) begin
          if (slot_index inside {[3'd0:3'd3]}) begin
            keep = 1'b1;
            cmd.kind = K_CORNER;
          end else if (slot_index == SLOT_NORMAL) begin
            keep = 1'b1;
            cmd.kind = K_NORMAL;
          end else if (slot_index == SLOT_OFFSET) begin
            keep = 1'b1;
            cmd.kind = K_OFFSET;
          end
        end
      end
      REQ_TRACE: begin
        keep = 1'b1;
        cmd.kind = K_TRACE;
      end
      REQ_QUERY: begin
        keep = 1'b1;
        cmd.kind = K_QUERY;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !full;
  assign push = in_valid && !full && keep;

endmodule

// ===== hw/rtl/rpi_fifo.sv =====
module rpi_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rpi_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output rpi_pkg::cmd_t rdata,
  output logic          empty
);
  import rpi_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          mem [QDEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;

  assign full = (cnt == CW'(QDEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == PW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

// ===== hw/rtl/rpi_div.sv =====
module rpi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] q
);
  import rpi_pkg::*;

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nsh;
  logic [NW-1:0] quo;
  logic [31:0]   rem;
  logic [31:0]   dm;
  logic [CW-1:0] cnt;
  logic          run;
  logic          neg;
  logic [32:0]   nmag;
  logic [32:0]   trial;
  logic          big_pos;
  logic          big_neg;

  assign nmag = num[32] ? 33'(-num) : 33'(num);
  assign trial = {rem, nsh[NW-1]} - {1'b0, dm};
  assign big_pos = |quo[NW-1:31];
  assign big_neg = (|quo[NW-1:32]) || (quo[31] && (|quo[30:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == CW'(NW)) begin
          run <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle, then saturation
  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= {nmag, {FRAC_BITS{1'b0}}};
      dm <= den[31] ? 32'(-den) : 32'(den);
      rem <= '0;
      quo <= '0;
      neg <= num[32] ^ den[31];
    end else if (run) begin
      if (cnt != CW'(NW)) begin
        nsh <= {nsh[NW-2:0], 1'b0};
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[30:0], nsh[NW-1]};
          quo <= {quo[NW-2:0], 1'b0};
        end
      end else begin
        if (neg) q <= big_neg ? 32'sh8000_0000 : 32'(-quo[31:0]);
        else q <= big_pos ? 32'sh7fff_ffff : quo[31:0];
      end
    end
  end

endmodule

// ===== hw/rtl/rpi_back.sv =====
module rpi_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        eps,
  input  logic               empty,
  input  rpi_pkg::cmd_t      cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z
);
  import rpi_pkg::*;

  localparam int CROWS = FACE_COUNT * CORNERS;
  localparam int AW = $clog2(CROWS);

  bstate_t st;
  bstate_t st_next;

  // corner rows {z, y, x}
  logic [95:0]        cmem [CROWS];
  logic [95:0]        crd;
  logic signed [31:0] nx [FACE_COUNT];
  logic signed [31:0] ny [FACE_COUNT];
  logic signed [31:0] nz [FACE_COUNT];
  logic signed [31:0] off [FACE_COUNT];

  logic [2:0]         f;
  logic [1:0]         k;
  logic [1:0]         e;
  logic [1:0]         cc;
  logic               is_trace;
  logic signed [31:0] va [3];
  logic signed [31:0] vb [3];
  logic signed [31:0] pt [3];
  logic signed [31:0] hit [3];
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic [63:0]        dsum;
  logic [63:0]        best;
  logic               have;
  logic signed [31:0] sn;
  logic signed [31:0] dc;
  logic signed [31:0] t;
  logic [95:0]        ce;
  logic signed [31:0] ex;
  logic signed [31:0] ey;
  logic signed [31:0] pxd;
  logic signed [31:0] pyd;
  logic signed [63:0] m0;
  logic [2:0]         pos;

  logic signed [31:0] n0, n1, n2;
  logic signed [31:0] opa, opb;
  logic signed [63:0] sh;
  logic [63:0]        shu;
  logic signed [31:0] dotv;
  logic [63:0]        dfin;
  logic signed [31:0] d [3];
  logic [1:0]         pl;
  logic [32:0]        absn2, absn0;
  logic signed [64:0] val;
  logic               gt;
  logic [2:0]         pfin;
  logic signed [32:0] num;
  logic signed [33:0] qdiff;
  logic [33:0]        qabs;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_q;
  logic [95:0]        ptrow;

  function automatic logic signed [31:0] sel_u(input logic [95:0] r, input logic [1:0] p);
    return (p == PL_ZY) ? r[95:64] : r[31:0];
  endfunction

  function automatic logic signed [31:0] sel_v(input logic [95:0] r, input logic [1:0] p);
    return (p == PL_XZ) ? r[95:64] : r[63:32];
  endfunction

  function automatic logic signed [31:0] dif(input logic signed [31:0] x,
                                             input logic signed [31:0] y);
    return sat33(33'(x) - 33'(y));
  endfunction

  assign n0 = nx[f];
  assign n1 = ny[f];
  assign n2 = nz[f];

  assign sh = prod >>> FRAC_BITS;
  assign shu = $unsigned(prod) >> FRAC_BITS;
  assign dotv = sat64(acc + sh);
  assign dfin = dsum + shu;
  assign ptrow = {pt[2], pt[1], pt[0]};

  always_comb begin
    for (int i = 0; i < 3; i++) d[i] = dif(pt[i], va[i]);
  end

  assign absn2 = n2[31] ? 33'(-33'(n2)) : 33'(n2);
  assign absn0 = n0[31] ? 33'(-33'(n0)) : 33'(n0);
  always_comb begin
    if (absn2 > {17'b0, eps}) pl = PL_XY;
    else if (absn0 > {17'b0, eps}) pl = PL_ZY;
    else pl = PL_XZ;
  end

  assign val = 65'(m0) - 65'(sh);
  assign gt = val > $signed({49'b0, eps});
  assign pfin = pos + {2'b0, gt};
  assign num = 33'(dc) - 33'(dotv);
  assign qdiff = 34'(dotv) - 34'(off[f]);
  assign qabs = qdiff[33] ? 34'(-qdiff) : 34'(qdiff);

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (st)
      S_SN: begin
        opa = pick3(vb[0], vb[1], vb[2], k);
        opb = pick3(n0, n1, n2, k);
      end
      S_DC: begin
        opa = pick3(crd[31:0], crd[63:32], crd[95:64], k);
        opb = pick3(n0, n1, n2, k);
      end
      S_DA, S_QD: begin
        opa = pick3(va[0], va[1], va[2], k);
        opb = pick3(n0, n1, n2, k);
      end
      S_PT: begin
        opa = pick3(vb[0], vb[1], vb[2], k);
        opb = t;
      end
      S_EMUL: begin
        opa = (k == 2'd0) ? ey : ex;
        opb = (k == 2'd0) ? pxd : pyd;
      end
      S_DIST: begin
        opa = pick3(d[0], d[1], d[2], k);
        opb = opa;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    crd <= cmem[AW'({f, cc})];
  end

  // face stores
  always_ff @(posedge clk) begin
    if (pop) begin
      case (cmd.kind)
        K_CORNER: cmem[AW'({cmd.face, cmd.corner})] <= {cmd.az, cmd.ay, cmd.ax};
        K_NORMAL: begin
          nx[cmd.face] <= cmd.ax;
          ny[cmd.face] <= cmd.ay;
          nz[cmd.face] <= cmd.az;
        end
        K_OFFSET: off[cmd.face] <= cmd.ax;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_next = st;
    pop = 1'b0;
    div_start = 1'b0;
    case (st)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (cmd.kind == K_TRACE) st_next = S_SN;
          else if (cmd.kind == K_QUERY) st_next = S_QD;
        end
      end
      S_SN: if (k == 2'd3) st_next = (dotv == '0) ? S_NEXT : S_DC;
      S_DC: if (k == 2'd3) st_next = S_DA;
      S_DA: begin
        if (k == 2'd3) begin
          div_start = 1'b1;
          st_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) st_next = (33'(div_q) < $signed({17'b0, eps})) ? S_NEXT : S_PT;
      end
      S_PT: if (k == 2'd3) st_next = S_EA;
      S_EA: st_next = S_EB;
      S_EB: st_next = S_EC;
      S_EC: st_next = S_ED;
      S_ED: st_next = S_EMUL;
      S_EMUL: begin
        if (k == 2'd2) begin
          if (e != 2'd3) st_next = S_EA;
          else st_next = (pfin == 3'd4 || pfin == 3'd0) ? S_DIST : S_NEXT;
        end
      end
      S_DIST: if (k == 2'd3) st_next = S_NEXT;
      S_QD: if (k == 2'd3) st_next = S_NEXT;
      S_NEXT: begin
        if (f == 3'(FACE_COUNT - 1)) st_next = S_OUT;
        else st_next = is_trace ? S_SN : S_QD;
      end
      S_OUT: if (!out_valid || out_ready) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (st == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_OUT && (!out_valid || out_ready)) begin
      found <= have;
      res_x <= hit[0];
      res_y <= hit[1];
      res_z <= hit[2];
    end
  end

  always_ff @(posedge clk) begin
    k <= (st_next != st) ? 2'd0 : k + 2'd1;
    case (st)
      S_IDLE: begin
        f <= '0;
        cc <= '0;
        have <= 1'b0;
        best <= '0;
        is_trace <= (cmd.kind == K_TRACE);
        va[0] <= cmd.ax;
        va[1] <= cmd.ay;
        va[2] <= cmd.az;
        vb[0] <= cmd.bx;
        vb[1] <= cmd.by;
        vb[2] <= cmd.bz;
        for (int i = 0; i < 3; i++) hit[i] <= '0;
      end
      S_SN, S_DC, S_DA, S_QD: begin
        acc <= (k == 2'd0) ? '0 : acc + sh;
        if (k == 2'd3) begin
          if (st == S_SN) sn <= dotv;
          if (st == S_DC) dc <= dotv;
          if (st == S_QD && qabs < {18'b0, eps}) begin
            have <= 1'b1;
            hit[0] <= n0;
            hit[1] <= n1;
            hit[2] <= n2;
          end
        end
      end
      S_DIV: begin
        if (div_done) t <= div_q;
        e <= '0;
        pos <= '0;
      end
      S_PT: begin
        case (k)
          2'd1: pt[0] <= sat65(65'(va[0]) + 65'(sh));
          2'd2: pt[1] <= sat65(65'(va[1]) + 65'(sh));
          2'd3: pt[2] <= sat65(65'(va[2]) + 65'(sh));
          default: ;
        endcase
      end
      S_EB: begin
        ce <= crd;
        cc <= e + 2'd1;
      end
      S_ED: begin
        ex <= dif(sel_u(crd, pl), sel_u(ce, pl));
        ey <= dif(sel_v(crd, pl), sel_v(ce, pl));
        pxd <= dif(sel_u(ptrow, pl), sel_u(ce, pl));
        pyd <= dif(sel_v(ptrow, pl), sel_v(ce, pl));
      end
      S_EMUL: begin
        if (k == 2'd1) m0 <= sh;
        if (k == 2'd2) begin
          pos <= pfin;
          e <= e + 2'd1;
        end
      end
      S_DIST: begin
        dsum <= (k == 2'd0) ? '0 : dfin;
        if (k == 2'd3 && (!have || dfin < best)) begin
          have <= 1'b1;
          best <= dfin;
          hit[0] <= pt[0];
          hit[1] <= pt[1];
          hit[2] <= pt[2];
        end
      end
      S_NEXT: begin
        f <= f + 3'd1;
        cc <= '0;
      end
      default: ;
    endcase
  end

  rpi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (sn),
    .done  (div_done),
    .q     (div_q)
  );

endmodule
